// ===== rtl/core/pls_pkg.sv =====
// Shared constants, register codes and the controller/datapath interface types
// for the pitch lag search unit. No dependencies.
`timescale 1ns / 1ps
package pls_pkg;

  localparam int FRAME_MAX = 256;
  localparam int AW = $clog2(FRAME_MAX);
  localparam int CW = AW + 1;
  localparam int CFG_W = 9;
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam int SAMPLE_W = 16;
  localparam int GF_W = 16;
  localparam int GAIN_W = 19;
  localparam int LAG_W = 9;
  localparam int IDX_W = 8;
  localparam int ACC_W = 48;
  localparam int PROD_W = 2 * ACC_W;
  localparam int MAC_DRAIN = 2;
  localparam int RATIO_STEPS = ACC_W;
  localparam int CNT_W = $clog2(RATIO_STEPS);
  localparam int QW = 16;
  localparam int QBIT_W = $clog2(QW);
  localparam int DIV_W = 64;
  localparam logic [QW-1:0] GAIN_HI = 16'd19661;
  localparam logic [QW-1:0] GAIN_LO_MAG = 16'd3277;
  localparam logic [QW-1:0] Q_SAT = 16'd32767;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_LEN   = 8'd0,
    REG_LAG_MIN     = 8'd1,
    REG_LAG_MAX     = 8'd2,
    REG_GAIN_FACTOR = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic            accept;
    logic            mac_clr;
    logic            mac_issue;
    logic [AW-1:0]   idx;
    logic [CW-1:0]   lag;
    logic            best_clr;
    logic            mul_start;
    logic            mul_step;
    logic            take_best;
    logic            div_start;
    logic            div_step;
    logic [QBIT_W-1:0] div_bit;
    logic            gain_mul;
    logic            out_load;
    logic            copy_rd;
    logic            frame_end;
  } pls_cmd_t;

  typedef struct packed {
    logic [CW-1:0] len;
    logic [CW-1:0] top;
    logic [CW-1:0] lag_min;
    logic          empty;
    logic          energy_zero;
    logic          better;
    logic          out_full;
  } pls_sts_t;

endpackage

// ===== rtl/core/pls_dp.sv =====
// Datapath of the pitch lag search unit: frame stores, multiply-accumulate,
// ratio compare, gain divider and output register. Depends on pls_pkg.
`timescale 1ns / 1ps
module pls_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pls_pkg::pls_cmd_t                 cmd_i,
  output pls_pkg::pls_sts_t                 sts_o,
  input  logic [pls_pkg::SAMPLE_W-1:0]      sample_i,
  input  logic                              restart_i,
  input  logic                              cfg_we_i,
  input  logic [pls_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [pls_pkg::GF_W-1:0]          cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [pls_pkg::GAIN_W-1:0]        out_gain_o,
  output logic [pls_pkg::LAG_W-1:0]         out_lag_o
);
  import pls_pkg::*;

  logic [CFG_W-1:0] frame_len_q, lag_min_q, lag_max_q;
  logic signed [GF_W-1:0] gain_factor_q;
  logic [CW-1:0] fill_q;
  logic have_prev_q, restart_seen_q, use_prev;
  logic [LW-1:0] len_w, top_w;
  logic [CW-1:0] len, top;

  logic signed [SAMPLE_W-1:0] cur_mem [FRAME_MAX];
  logic signed [SAMPLE_W-1:0] prev_mem [FRAME_MAX];
  logic signed [SAMPLE_W-1:0] x_rd_q, dc_rd_q, dp_rd_q, d_sel;
  logic [AW-1:0] dc_addr, dp_addr, copy_a_q;
  logic [CW:0] dp_sum;
  logic in_cur, v1_q, sel1_q, v2_q, copy_v_q;
  logic signed [2*SAMPLE_W-1:0] px_q, pd_q;
  logic signed [ACC_W-1:0] corr_q, best_c_q;
  logic [ACC_W-1:0] en_q, best_e_q, corr_mag, best_mag;
  logic [CW-1:0] best_lag_q;

  logic [PROD_W-1:0] ma_q, na_q, pa_q, pb_q;
  logic [ACC_W-1:0] mb_q, nb_q;
  logic n1, n2, gt;

  logic [DIV_W-1:0] rem_q, div_n, div_d, div_s;
  logic [QW-2:0] q_q;
  logic sat_q;
  logic [QW-1:0] qmag, g_mag;
  logic signed [QW-1:0] g;
  logic signed [QW+GF_W-1:0] gprod_q;
  logic signed [QW+GF_W:0] psum, pshift;
  logic signed [GAIN_W-1:0] p_sat;
  logic out_valid_q;
  logic [GAIN_W-1:0] out_gain_q;
  logic [LAG_W-1:0] out_lag_q;

  // Frame length out of range is forced into 1..FRAME_MAX.
  always_comb begin
    if (frame_len_q == '0) begin
      len_w = LW'(1);
    end else if (LW'(frame_len_q) > LW'(FRAME_MAX)) begin
      len_w = LW'(FRAME_MAX);
    end else begin
      len_w = LW'(frame_len_q);
    end
    top_w = (LW'(lag_max_q) > len_w) ? len_w : LW'(lag_max_q);
  end
  assign len = CW'(len_w);
  assign top = CW'(top_w);
  assign use_prev = have_prev_q & ~restart_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q    <= CFG_W'(256);
      lag_min_q      <= CFG_W'(20);
      lag_max_q      <= CFG_W'(147);
      gain_factor_q  <= 16'sd4096;
      fill_q         <= '0;
      have_prev_q    <= 1'b0;
      restart_seen_q <= 1'b0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      copy_v_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_FRAME_LEN:   frame_len_q   <= cfg_data_i[CFG_W-1:0];
          REG_LAG_MIN:     lag_min_q     <= cfg_data_i[CFG_W-1:0];
          REG_LAG_MAX:     lag_max_q     <= cfg_data_i[CFG_W-1:0];
          REG_GAIN_FACTOR: gain_factor_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        if (fill_q < CW'(FRAME_MAX)) begin
          fill_q <= fill_q + 1'b1;
        end
        if (restart_i) begin
          restart_seen_q <= 1'b1;
        end
      end
      if (cmd_i.frame_end) begin
        fill_q         <= '0;
        restart_seen_q <= 1'b0;
        have_prev_q    <= 1'b1;
      end
      v1_q     <= cmd_i.mac_issue & (in_cur | use_prev);
      v2_q     <= v1_q;
      copy_v_q <= cmd_i.copy_rd;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Delayed-signal addresses: inside the current frame, or wrapped into the previous one.
  assign in_cur  = {1'b0, cmd_i.idx} >= cmd_i.lag;
  assign dc_addr = AW'({1'b0, cmd_i.idx} - cmd_i.lag);
  assign dp_sum  = (CW+1)'(len) + (CW+1)'(cmd_i.idx) - (CW+1)'(cmd_i.lag);
  assign dp_addr = dp_sum[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && fill_q < CW'(FRAME_MAX)) begin
      cur_mem[fill_q[AW-1:0]] <= $signed(sample_i);
    end
    x_rd_q  <= cur_mem[cmd_i.idx];
    dc_rd_q <= cur_mem[dc_addr];
    dp_rd_q <= prev_mem[dp_addr];
    copy_a_q <= cmd_i.idx;
    if (copy_v_q) begin
      prev_mem[copy_a_q] <= x_rd_q;
    end
  end

  assign d_sel = sel1_q ? dc_rd_q : dp_rd_q;

  always_ff @(posedge clk_i) begin
    sel1_q <= in_cur;
    px_q   <= x_rd_q * d_sel;
    pd_q   <= d_sel * d_sel;
    if (cmd_i.mac_clr) begin
      corr_q <= '0;
      en_q   <= '0;
    end else if (v2_q) begin
      corr_q <= corr_q + ACC_W'(px_q);
      en_q   <= en_q + ACC_W'($unsigned(pd_q));
    end
  end

  assign corr_mag = corr_q[ACC_W-1] ? $unsigned(-corr_q) : $unsigned(corr_q);
  assign best_mag = best_c_q[ACC_W-1] ? $unsigned(-best_c_q) : $unsigned(best_c_q);

  // Shift-and-add products |corr|*best_energy and |best_corr|*energy, one bit a cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.best_clr) begin
      best_c_q   <= '0;
      best_e_q   <= '0;
      best_lag_q <= '0;
    end else if (cmd_i.take_best) begin
      best_c_q   <= corr_q;
      best_e_q   <= en_q;
      best_lag_q <= cmd_i.lag;
    end
    if (cmd_i.mul_start) begin
      ma_q <= PROD_W'(corr_mag);
      mb_q <= best_e_q;
      na_q <= PROD_W'(best_mag);
      nb_q <= en_q;
      pa_q <= '0;
      pb_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (mb_q[0]) pa_q <= pa_q + ma_q;
      if (nb_q[0]) pb_q <= pb_q + na_q;
      ma_q <= ma_q << 1;
      na_q <= na_q << 1;
      mb_q <= mb_q >> 1;
      nb_q <= nb_q >> 1;
    end
  end

  assign n1 = corr_q[ACC_W-1];
  assign n2 = best_c_q[ACC_W-1];
  always_comb begin
    if (n1 != n2) begin
      gt = ~n1;
    end else if (n1) begin
      gt = pa_q < pb_q;
    end else begin
      gt = pa_q > pb_q;
    end
  end

  // Rounded quotient |c|*2^14/e by restoring division; quotients of 2^15 and up saturate.
  assign div_n = (DIV_W'(best_mag) << 15) + DIV_W'(best_e_q);
  assign div_d = DIV_W'(best_e_q) << 1;
  assign div_s = div_d << cmd_i.div_bit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= div_n;
      sat_q <= div_n >= (div_d << (QW - 1));
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= div_s) begin
        rem_q <= rem_q - div_s;
        q_q[cmd_i.div_bit] <= 1'b1;
      end
    end
    if (cmd_i.gain_mul) begin
      gprod_q <= g * gain_factor_q;
    end
    if (cmd_i.out_load) begin
      out_gain_q <= $unsigned(p_sat);
      out_lag_q  <= LAG_W'(best_lag_q);
    end
  end

  always_comb begin
    qmag = sat_q ? Q_SAT : {1'b0, q_q};
    if (n2) begin
      g_mag = (qmag > GAIN_LO_MAG) ? GAIN_LO_MAG : qmag;
    end else begin
      g_mag = (qmag > GAIN_HI) ? GAIN_HI : qmag;
    end
    if (best_e_q == '0) begin
      g = '0;
    end else if (n2) begin
      g = -$signed(g_mag);
    end else begin
      g = $signed(g_mag);
    end
  end

  assign psum   = (QW+GF_W+1)'(gprod_q) + (QW+GF_W+1)'(2048);
  assign pshift = psum >>> 12;
  always_comb begin
    if (pshift > (QW+GF_W+1)'(262143)) begin
      p_sat = GAIN_W'(262143);
    end else if (pshift < -(QW+GF_W+1)'(262144)) begin
      p_sat = GAIN_W'(-262144);
    end else begin
      p_sat = GAIN_W'(pshift);
    end
  end

  assign sts_o.len         = len;
  assign sts_o.top         = top;
  assign sts_o.lag_min     = CW'(lag_min_q);
  assign sts_o.empty       = LW'(lag_min_q) > top_w;
  assign sts_o.energy_zero = en_q == '0;
  assign sts_o.better      = (best_e_q == '0) | gt;
  assign sts_o.out_full    = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_gain_o  = out_gain_q;
  assign out_lag_o   = out_lag_q;

endmodule

// ===== rtl/core/pls_ctrl.sv =====
// Sequencer of the pitch lag search unit: steps lags, samples, compare,
// division, output and frame copy. Depends on pls_pkg.
`timescale 1ns / 1ps
module pls_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  pls_pkg::pls_sts_t sts_i,
  output pls_pkg::pls_cmd_t cmd_o
);
  import pls_pkg::*;

  typedef enum logic [3:0] {
    IDLE, SEARCH, LAG_INIT, MAC, DRAIN, CHECK, MUL, DECIDE,
    DIV_INIT, DIV, GMUL, OUT, COPY, COPY_END
  } state_e;

  state_e state_q;
  logic [CW-1:0] lag_q;
  logic [AW-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic in_acc, last_lag;

  assign in_ready_o = state_q == IDLE;
  assign in_acc = in_valid_i & in_ready_o;
  assign last_lag = lag_q == sts_i.top;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      lag_q   <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        IDLE: begin
          if (in_acc && in_last_i) state_q <= SEARCH;
        end
        SEARCH: begin
          lag_q   <= sts_i.lag_min;
          state_q <= sts_i.empty ? DIV_INIT : LAG_INIT;
        end
        LAG_INIT: begin
          idx_q   <= '0;
          state_q <= MAC;
        end
        MAC: begin
          if ({1'b0, idx_q} == sts_i.len - 1'b1) begin
            cnt_q   <= '0;
            state_q <= DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        DRAIN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(MAC_DRAIN - 1)) state_q <= CHECK;
        end
        CHECK: begin
          cnt_q <= '0;
          if (!sts_i.energy_zero) begin
            state_q <= MUL;
          end else if (last_lag) begin
            state_q <= DIV_INIT;
          end else begin
            lag_q   <= lag_q + 1'b1;
            state_q <= LAG_INIT;
          end
        end
        MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(RATIO_STEPS - 1)) state_q <= DECIDE;
        end
        DECIDE: begin
          if (last_lag) begin
            state_q <= DIV_INIT;
          end else begin
            lag_q   <= lag_q + 1'b1;
            state_q <= LAG_INIT;
          end
        end
        DIV_INIT: begin
          cnt_q   <= CNT_W'(QW - 2);
          state_q <= DIV;
        end
        DIV: begin
          if (cnt_q == '0) begin
            state_q <= GMUL;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        GMUL: state_q <= OUT;
        OUT: begin
          if (!sts_i.out_full) begin
            idx_q   <= '0;
            state_q <= COPY;
          end
        end
        COPY: begin
          if (idx_q == AW'(FRAME_MAX - 1)) begin
            state_q <= COPY_END;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        COPY_END: state_q <= IDLE;
        default: state_q <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = in_acc;
    cmd_o.idx       = idx_q;
    cmd_o.lag       = lag_q;
    cmd_o.div_bit   = cnt_q[QBIT_W-1:0];
    cmd_o.best_clr  = state_q == SEARCH;
    cmd_o.mac_clr   = state_q == LAG_INIT;
    cmd_o.mac_issue = state_q == MAC;
    cmd_o.mul_start = (state_q == CHECK) && !sts_i.energy_zero;
    cmd_o.mul_step  = state_q == MUL;
    cmd_o.take_best = (state_q == DECIDE) && sts_i.better;
    cmd_o.div_start = state_q == DIV_INIT;
    cmd_o.div_step  = state_q == DIV;
    cmd_o.gain_mul  = state_q == GMUL;
    cmd_o.out_load  = (state_q == OUT) && !sts_i.out_full;
    cmd_o.copy_rd   = state_q == COPY;
    cmd_o.frame_end = state_q == COPY_END;
  end

endmodule

// ===== rtl/core/pitch_lag_search_unit.sv =====
// Sequence: a frame's last sample starts a setup step, then a search over the lags in which
// each lag runs the frame through the single shared multiply-accumulate, drains it and, if
// the energy is non-zero, runs the bit-serial ratio compare; then division and gain, the
// output, and the copy of FRAME_MAX samples into the previous frame. Throughput: one sample a
// cycle, but input stalls from a frame's last sample until its copy ends. Reset (async, active
// low) clears control and loads register defaults; frame stores are not cleared.
// Top level of the pitch lag search unit. Depends on pls_pkg, pls_ctrl and pls_dp.
`timescale 1ns / 1ps
module pitch_lag_search_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] sample
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tuser_i,  // [0] restart
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [18:0] gain, [27:19] lag, [31:28] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [pls_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import pls_pkg::*;

  pls_cmd_t cmd;
  pls_sts_t sts;
  logic [GAIN_W-1:0] gain;
  logic [LAG_W-1:0] lag;

  assign cfg_ready_o = 1'b1;

  pls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pls_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata_i),
    .restart_i   (s_axis_tuser_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_gain_o  (gain),
    .out_lag_o   (lag)
  );

  assign m_axis_tdata_o = {4'b0, lag, gain};

endmodule

// ===== rtl/core/pls_checker.sv =====
// Port-level checks for the pitch lag search unit, bound to the top level.
// Depends on pls_pkg.
`timescale 1ns / 1ps
module pls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);
  import pls_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // A frame's last sample starts a search, which stops input.
  a_search_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input accepted right after frame end");

  // A new result only appears while input is held off after a frame's last sample.
  a_out_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !s_axis_tready_o)
    else $error("result appeared while idle");

  // The lag never exceeds the frame store depth.
  a_lag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[27:19] <= LAG_W'(FRAME_MAX))
    else $error("lag out of range");

endmodule

bind pitch_lag_search_unit pls_checker u_pls_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== bench/pitch_lag_search_checker.sv =====
// Checker for the pitch lag search unit: watches the sample, result and register
// channels, predicts each frame's lag and gain, and compares. Depends on pls_pkg.
`timescale 1ns / 1ps
module pitch_lag_search_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [15:0] s_data_i,
  input  logic        s_last_i,
  input  logic        s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [31:0] m_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [pls_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import pls_pkg::*;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [LAG_W-1:0]  lag;
  } pitch_res_t;

  pitch_res_t lag_gain_q[$];

  logic [8:0]         len_reg, lmin_reg, lmax_reg;
  logic signed [15:0] gf_reg;
  logic signed [15:0] cur_mem  [FRAME_MAX];
  logic signed [15:0] prev_mem [FRAME_MAX];
  logic               prev_ok, restart_hit;
  int                 fill;
  int                 n_err;

  // Exhaustive lag search over the stored frames, as the block should do it.
  function automatic pitch_res_t search_pitch();
    int len, top, lag, i;
    longint corr, en, bc, be, x, d, m, q, g, p;
    logic signed [95:0] pa, pb;
    logic found, use_prev;
    pitch_res_t r;
    len = (len_reg == 0) ? 1 : ((len_reg > FRAME_MAX) ? FRAME_MAX : int'(len_reg));
    top = (int'(lmax_reg) > len) ? len : int'(lmax_reg);
    use_prev = prev_ok && !restart_hit;
    found = 1'b0;
    bc = 0; be = 0; g = 0;
    r.lag = '0;
    for (lag = int'(lmin_reg); lag <= top; lag++) begin
      corr = 0; en = 0;
      for (i = lag; i < len; i++) begin
        x = cur_mem[i]; d = cur_mem[i-lag];
        corr += x * d; en += d * d;
      end
      if (use_prev)
        for (i = 0; i < lag; i++) begin
          x = cur_mem[i]; d = prev_mem[len+i-lag];
          corr += x * d; en += d * d;
        end
      if (en == 0) continue;
      // Cross-multiplied: corr/en > bc/be with both energies positive.
      pa = corr; pa = pa * be;
      pb = bc;   pb = pb * en;
      if (!found || pa > pb) begin
        found = 1'b1; bc = corr; be = en; r.lag = lag[8:0];
      end
    end
    if (found) begin
      m = (bc < 0) ? -bc : bc;
      q = (2 * m * 16384 + be) / (2 * be);
      g = (bc < 0) ? -q : q;
      if (g > 19661) g = 19661;
      if (g < -3277) g = -3277;
    end
    p = (g * longint'(gf_reg) + 2048) >>> 12;
    if (p > 262143) p = 262143;
    if (p < -262144) p = -262144;
    r.gain = p[18:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pitch_res_t exp_r;
    if (!rst_ni) begin
      len_reg <= 9'd256; lmin_reg <= 9'd20; lmax_reg <= 9'd147; gf_reg <= 16'sd4096;
      prev_ok = 1'b0; restart_hit = 1'b0; fill = 0;
      lag_gain_q.delete();
      n_err <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FRAME_LEN:   len_reg  <= cfg_data_i[8:0];
          REG_LAG_MIN:     lmin_reg <= cfg_data_i[8:0];
          REG_LAG_MAX:     lmax_reg <= cfg_data_i[8:0];
          REG_GAIN_FACTOR: gf_reg   <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        // Blocking updates here so the search sees this sample at once.
        if (fill < FRAME_MAX) begin
          cur_mem[fill] = s_data_i;
          fill = fill + 1;
        end
        if (s_user_i) restart_hit = 1'b1;
        if (s_last_i) begin
          lag_gain_q.push_back(search_pitch());
          prev_mem = cur_mem;
          prev_ok = 1'b1;
          restart_hit = 1'b0;
          fill = 0;
        end
      end
      if (m_valid_i && m_ready_i) begin
        if (lag_gain_q.size() == 0) begin
          if (n_err < 10) $display("ERROR: unexpected result %h", m_data_i);
          n_err <= n_err + 1;
        end else begin
          exp_r = lag_gain_q.pop_front();
          if (m_data_i[18:0] !== exp_r.gain || m_data_i[27:19] !== exp_r.lag
              || m_data_i[31:28] !== 4'd0) begin
            if (n_err < 10)
              $display("ERROR: result gain %0d lag %0d pad %h, expected gain %0d lag %0d",
                       $signed(m_data_i[18:0]), m_data_i[27:19], m_data_i[31:28],
                       $signed(exp_r.gain), exp_r.lag);
            n_err <= n_err + 1;
          end
        end
      end
    end
  end

  assign fail_count_o = n_err;
  assign pending_o    = lag_gain_q.size();
endmodule

// ===== bench/pitch_lag_search_unit_test.sv =====
// Testbench top for the pitch lag search unit: clock, reset, sample, result and
// register stimulus, and the verdict. Depends on pls_pkg and pitch_lag_search_checker.
`timescale 1ns / 1ps
module pitch_lag_search_unit_test;
  import pls_pkg::*;

  localparam int QUIET_LIMIT = 400000;
  localparam int SETTLE      = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0, s_last = 1'b0, s_user = 1'b0;
  logic [15:0] s_data = '0;
  logic        s_ready;
  logic        m_valid, m_ready = 1'b0;
  logic [31:0] m_data;
  logic        cfg_valid = 1'b0, cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_fire = 1'b0, m_fire = 1'b0, c_fire = 1'b0;
  logic        hold_req = 1'b0;
  int          fails, pending;
  int          quiet = 0, n_samples = 0, n_frames = 0, n_writes = 0;
  logic [8:0]  cur_len = 9'd256;

  always #5 clk_i = ~clk_i;

  pitch_lag_search_unit u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .s_axis_tlast_i(s_last), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  pitch_lag_search_checker u_check (
    .clk_i, .rst_ni,
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_last_i(s_last),
    .s_user_i(s_user), .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .fail_count_o(fails), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    s_fire <= s_valid && s_ready;
    m_fire <= m_valid && m_ready;
    c_fire <= cfg_valid && cfg_ready;
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (rst_ni)
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random ready pattern, plus one long hold-off on request.
  initial begin
    int n;
    logic burst;
    burst = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (4000) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (burst) begin
        m_ready <= 1'b1;
        repeat ($urandom_range(20, 200)) @(negedge clk_i);
        burst = ($urandom_range(0, 3) == 0);
      end else begin
        n = pick_gap();
        m_ready <= (n == 0);
        if (n > 0) repeat (n) @(negedge clk_i);
        burst = ($urandom_range(0, 30) == 0);
      end
    end
  end

  task automatic put_sample(input logic [15:0] x, input logic last, input logic rs);
    int n;
    n = pick_gap();
    if (n > 0) begin
      s_valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_data <= x; s_last <= last; s_user <= rs; s_valid <= 1'b1;
    @(negedge clk_i);
    while (!s_fire) @(negedge clk_i);
    n_samples++;
    if (last) n_frames++;
  endtask

  // Registers change only once every result is out and the frame copy has finished.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
    s_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
    @(negedge clk_i);
    while (!c_fire) @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_LEN) cur_len = val[8:0];
    n_writes++;
  endtask

  // One frame of n samples; kind picks the signal shape.
  task automatic put_frame(input int n, input int kind, input int rs_pct);
    logic [15:0] pat[16];
    int per, i, k;
    logic rs;
    per = $urandom_range(1, 16);
    for (k = 0; k < 16; k++) pat[k] = $urandom;
    for (i = 0; i < n; i++) begin
      rs = ($urandom_range(0, 99) < rs_pct);
      case (kind)
        0: put_sample($urandom, i == n - 1, rs);
        1: put_sample(pat[i % per] + 16'($urandom_range(0, 7)), i == n - 1, rs);
        2: put_sample(16'($signed(5'($urandom))), i == n - 1, rs);
        3: put_sample(($urandom_range(0, 1)) ? 16'h7fff : 16'h8000, i == n - 1, rs);
        default: put_sample(16'h0000, i == n - 1, rs);
      endcase
    end
  endtask

  function automatic int eff_len();
    return (cur_len == 0) ? 1 : ((cur_len > 256) ? 256 : int'(cur_len));
  endfunction

  initial begin
    int len, lmin, lmax, nf, f, n, r;
    logic hold_done;
    hold_done = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Overlong first frame fills both stores completely, with extreme samples.
    put_frame(260, 3, 0);
    write_reg(REG_FRAME_LEN, 16'd4);
    write_reg(REG_LAG_MIN, 16'd1);
    write_reg(REG_LAG_MAX, 16'd4);
    put_frame(4, 4, 100);                    // zero energy everywhere
    write_reg(REG_GAIN_FACTOR, 16'h7fff);
    put_frame(4, 3, 0);
    write_reg(REG_GAIN_FACTOR, 16'h8000);
    put_sample(16'h7fff, 1'b0, 1'b0); put_sample(16'h8000, 1'b0, 1'b0);
    put_sample(16'h7fff, 1'b0, 1'b0); put_sample(16'h8000, 1'b1, 1'b0);
    write_reg(REG_LAG_MIN, 16'd5);            // empty lag range
    write_reg(REG_LAG_MAX, 16'd2);
    put_frame(3, 0, 0);                       // also a short frame
    write_reg(REG_FRAME_LEN, 16'd0);
    write_reg(REG_LAG_MIN, 16'd0);
    write_reg(REG_LAG_MAX, 16'd256);
    put_frame(1, 0, 0);
    write_reg(8'hA5, 16'h1234);               // unused register index

    while (n_samples < 1650) begin
      r = $urandom_range(0, 99);
      if (r < 3) len = 256 + $urandom_range(0, 255);
      else if (r < 8) len = $urandom_range(0, 2);
      else len = $urandom_range(3, 40);
      write_reg(REG_FRAME_LEN, {7'($urandom), 9'(len)});
      n = eff_len();
      if (len > 255) begin
        lmin = $urandom_range(0, 256); lmax = (lmin + 12 > 256) ? 256 : lmin + 12;
      end else begin
        lmin = $urandom_range(0, n + 2);
        lmax = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511) : $urandom_range(0, n + 2);
      end
      write_reg(REG_LAG_MIN, {7'($urandom), 9'(lmin)});
      write_reg(REG_LAG_MAX, {7'($urandom), 9'(lmax)});
      r = $urandom_range(0, 9);
      write_reg(REG_GAIN_FACTOR, (r == 0) ? 16'h8000 : (r == 1) ? 16'h7fff :
                (r < 5) ? 16'd4096 : 16'($urandom));
      nf = $urandom_range(1, 4);
      // Several frames while the receiver holds off, so the output stalls the input.
      if (n_frames > 20 && !hold_done) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
        nf = 3;
      end
      for (f = 0; f < nf; f++) begin
        r = $urandom_range(0, 99);
        if (r < 75) put_frame(n, (r < 40) ? 1 : 0, 5);
        else if (r < 85) put_frame($urandom_range(1, n), $urandom_range(0, 4), 10);
        else if (r < 95) put_frame(n + $urandom_range(1, 6), $urandom_range(0, 3), 10);
        else put_frame(n, $urandom_range(2, 4), 50);
      end
    end

    s_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    $display("Ran %0d samples in %0d frames with %0d register writes.",
             n_samples, n_frames, n_writes);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fails, pending);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
